// ===== design/lfl_pkg.sv =====
// Shared types and constants of the length-framed label parser.
// Used by lfl_parse and length_framed_label_parser; no dependencies.

package lfl_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] ID_A     = 8'h29;
  localparam logic [7:0] ID_B     = 8'h30;
  localparam logic [7:0] FN_A     = 8'h05;
  localparam logic [7:0] FN_B     = 8'hA4;
  localparam logic [7:0] FILLER   = 8'h0A;

  localparam logic [7:0] LENGTH_LIMIT_RESET     = 8'd50;
  localparam logic [7:0] FRAMES_PER_LABEL_RESET = 8'd2;

  // Register index, taken from byte address bit 2.
  localparam logic REG_LENGTH_LIMIT     = 1'b0;
  localparam logic REG_FRAMES_PER_LABEL = 1'b1;

  localparam int CAPTURE_DEPTH = 3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ID      = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] event_code;
    logic [7:0] first_value;
    logic [7:0] second_value;
    logic [8:0] label_sum;
    logic       label_ready;
  } result_t;

endpackage

// ===== design/lfl_parse.sv =====
// Frame parser core: phase machine, capture of frame positions 4 to 6 and
// the frame tally. Produces one result per trailer beat. Depends on lfl_pkg.

module lfl_parse
  import lfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] length_limit,
  input  logic [7:0] frames_per_label,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [7:0] cap [CAPTURE_DEPTH];
  logic [7:0] cap_next [CAPTURE_DEPTH];
  logic [7:0] tally;
  logic [7:0] tally_next;

  logic [8:0] tally_plus;
  logic       label_hit;
  logic [1:0] pos_after;
  logic [7:0] fin [CAPTURE_DEPTH];

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT:    phase_next = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT;
      PH_ID:      phase_next = (rx_byte == ID_A || rx_byte == ID_B) ? PH_FUNC : PH_HUNT;
      PH_FUNC:    phase_next = (rx_byte == FN_A || rx_byte == FN_B) ? PH_LENGTH : PH_HUNT;
      PH_LENGTH:  phase_next = (rx_byte < length_limit) ? PH_PAYLOAD : PH_HUNT;
      PH_PAYLOAD: begin
        if (bytes_left == 8'd0) begin
          phase_next = PH_HUNT;
        end else if (bytes_left == 8'd1) begin
          phase_next = PH_TRAILER;
        end
      end
      PH_TRAILER: phase_next = PH_HUNT;
      default:    phase_next = PH_HUNT;
    endcase
  end

  // Final capture on the trailer beat: the trailer goes to the next free
  // position and the newline filler to the one after it.
  assign pos_after = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
  always_comb begin
    for (int i = 0; i < CAPTURE_DEPTH; i++) begin
      fin[i] = cap[i];
      if (pos == 2'(i)) begin
        fin[i] = rx_byte;
      end else if (pos_after == 2'(i) && pos != 2'd3) begin
        fin[i] = FILLER;
      end
    end
  end

  assign tally_plus = {1'b0, tally} + 9'd1;
  assign label_hit  = tally_plus >= {1'b0, frames_per_label};

  // Datapath updates and result.
  always_comb begin
    bytes_left_next = bytes_left;
    pos_next        = pos;
    tally_next      = tally;
    for (int i = 0; i < CAPTURE_DEPTH; i++) begin
      cap_next[i] = cap[i];
    end
    res_valid             = 1'b0;
    res.event_code        = fin[0];
    res.first_value       = fin[1];
    res.second_value      = fin[2];
    res.label_ready       = label_hit;
    res.label_sum         = label_hit ? ({1'b0, fin[1]} + {1'b0, fin[2]}) : 9'd0;
    unique case (phase)
      PH_LENGTH: begin
        if (rx_byte < length_limit) begin
          bytes_left_next = rx_byte;
          pos_next        = 2'd0;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left != 8'd0) begin
          bytes_left_next = bytes_left - 8'd1;
          pos_next        = pos_after;
          for (int i = 0; i < CAPTURE_DEPTH; i++) begin
            if (pos == 2'(i)) begin
              cap_next[i] = rx_byte;
            end
          end
        end
      end
      PH_TRAILER: begin
        res_valid  = accept;
        tally_next = label_hit ? 8'd0 : tally_plus[7:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      bytes_left <= 8'd0;
      pos        <= 2'd0;
      tally      <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      pos        <= pos_next;
      tally      <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CAPTURE_DEPTH; i++) begin
        cap[i] <= cap_next[i];
      end
    end
  end

endmodule

// ===== design/length_framed_label_parser.sv =====
// Length-framed label parser: top level with register port and output buffer.
// Depends on lfl_pkg and lfl_parse.
//
// Usage: received bytes enter one beat at a time on rx_valid / rx_stall /
// rx_byte. Frames are 0xAA, id, function code, length, payload, trailer.
// Each trailer beat yields one result beat on result_valid / result_stall
// with event_code, first_value, second_value, label_sum and label_ready.
// A trailer beat's result is registered into the output register, or into
// its one skid entry while that register is held, so a byte is still taken
// while a result waits. Throughput: one byte per cycle while rx_stall is
// low, set by the single parse register stage. rx_stall rises only once
// both entries hold results, and drops the cycle after one is taken.
// Registers on the APB port: length_limit at 0x0, frames_per_label at 0x4;
// write them only while the block is idle. Synchronous rst returns the
// parser to hunting, clears the frame tally, empties the output buffer and
// restores the register reset values (50 and 2).

module length_framed_label_parser
  import lfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  event_code,
  output logic [7:0]  first_value,
  output logic [7:0]  second_value,
  output logic [8:0]  label_sum,
  output logic        label_ready
);

  logic [7:0] length_limit;
  logic [7:0] frames_per_label;
  logic       cfg_write;

  logic       accept;
  logic       res_valid;
  result_t    res;

  logic       out_valid;
  result_t    out_res;
  logic       skid_valid;
  result_t    skid_res;
  logic       out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit     <= LENGTH_LIMIT_RESET;
      frames_per_label <= FRAMES_PER_LABEL_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LENGTH_LIMIT:     length_limit     <= pwdata[7:0];
        REG_FRAMES_PER_LABEL: frames_per_label <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LENGTH_LIMIT:     prdata = {24'd0, length_limit};
      REG_FRAMES_PER_LABEL: prdata = {24'd0, frames_per_label};
      default:              prdata = 32'd0;
    endcase
  end

  assign rx_stall = skid_valid;
  assign accept   = rx_valid && !rx_stall;

  lfl_parse u_parse (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (rx_byte),
    .length_limit     (length_limit),
    .frames_per_label (frames_per_label),
    .res_valid        (res_valid),
    .res              (res)
  );

  // The output slot can take a new beat when empty or being taken now.
  assign out_free = !out_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_free) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        out_res <= skid_res;
      end
    end else if (out_free) begin
      if (res_valid) begin
        out_res <= res;
      end
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

  assign result_valid = out_valid;
  assign event_code   = out_res.event_code;
  assign first_value  = out_res.first_value;
  assign second_value = out_res.second_value;
  assign label_sum    = out_res.label_sum;
  assign label_ready  = out_res.label_ready;

endmodule
